/* rtl/vwbd_pkg.sv */
// shared types and constants for the vertex weld by distance block
`default_nettype none

package vwbd_pkg;

	// store geometry
	localparam int MAX_UNIQUE = 1024;
	localparam int IDX_W      = $clog2(MAX_UNIQUE);
	localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);

	// field widths
	localparam int COORD_W = 16;
	localparam int COLOR_W = 8;
	localparam int SQ_W    = 2 * COORD_W;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// status from the distance unit back to the sequencer
	typedef struct packed {
		logic hit;
		logic pending;
	} dist_status_t;

endpackage

`default_nettype wire

/* rtl/vwbd_store.sv */
// position store: one write port, one registered read port
`default_nettype none

module vwbd_store (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [vwbd_pkg::IDX_W-1:0]           wr_addr,
	input  wire logic [2*vwbd_pkg::COORD_W-1:0]       wr_data,
	input  wire logic [vwbd_pkg::IDX_W-1:0]           rd_addr,
	output logic      [2*vwbd_pkg::COORD_W-1:0]       rd_data
);

	logic [2*vwbd_pkg::COORD_W-1:0] mem_q [vwbd_pkg::MAX_UNIQUE];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/vwbd_dist.sv */
// shared distance unit: absolute differences, squares, sum and compare
`default_nettype none

module vwbd_dist (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 flush,
	input  wire logic [vwbd_pkg::COORD_W-1:0]         ref_x,
	input  wire logic [vwbd_pkg::COORD_W-1:0]         ref_y,
	input  wire logic [vwbd_pkg::COORD_W-1:0]         kept_x,
	input  wire logic [vwbd_pkg::COORD_W-1:0]         kept_y,
	input  wire logic [vwbd_pkg::SQ_W-1:0]            limit,
	output vwbd_pkg::dist_status_t                    status
);

	logic [vwbd_pkg::COORD_W:0]   dx;
	logic [vwbd_pkg::COORD_W:0]   dy;
	logic [vwbd_pkg::COORD_W:0]   dx_abs;
	logic [vwbd_pkg::COORD_W:0]   dy_abs;
	logic [vwbd_pkg::COORD_W-1:0] ax_s1;
	logic [vwbd_pkg::COORD_W-1:0] ay_s1;
	logic                         v_s1;
	logic [vwbd_pkg::SQ_W-1:0]    sqx_s2;
	logic [vwbd_pkg::SQ_W-1:0]    sqy_s2;
	logic                         v_s2;
	logic [vwbd_pkg::SQ_W:0]      sum;

	// signed differences, sign extended by one bit
	always_comb begin
		dx     = {ref_x[vwbd_pkg::COORD_W-1], ref_x} - {kept_x[vwbd_pkg::COORD_W-1], kept_x};
		dy     = {ref_y[vwbd_pkg::COORD_W-1], ref_y} - {kept_y[vwbd_pkg::COORD_W-1], kept_y};
		dx_abs = dx[vwbd_pkg::COORD_W] ? -dx : dx;
		dy_abs = dy[vwbd_pkg::COORD_W] ? -dy : dy;
	end

	// stage 1: magnitudes
	always_ff @(posedge clk) begin
		ax_s1 <= dx_abs[vwbd_pkg::COORD_W-1:0];
		ay_s1 <= dy_abs[vwbd_pkg::COORD_W-1:0];
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		sqx_s2 <= ax_s1 * ax_s1;
		sqy_s2 <= ay_s1 * ay_s1;
	end

	// valid flags follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid & ~flush;
			v_s2 <= v_s1 & ~flush;
		end
	end

	// sum and strict compare against the squared threshold
	always_comb begin
		sum            = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		status.hit     = v_s2 & (sum < {1'b0, limit});
		status.pending = v_s1 | v_s2;
	end

endmodule

`default_nettype wire

/* rtl/vertex_weld_by_distance_unit.sv */
// top level: sequencer, configuration and result registers for vertex welding
`default_nettype none

// Each request (start high while busy is low) compares the vertex with every
// kept position, one stored entry per cycle through a single pipelined
// distance unit fed by the position store read port. A request keeps busy high
// through the scan of the N kept positions (N counted after first_of_set
// empties the store) and the finishing state; the scan ends early at the
// first position closer than the threshold. The result appears for one cycle
// with done high and cannot be held off; busy is already low in that cycle,
// so the next request may be given alongside it. distance_threshold is
// written while cfg_we is high; the user must write it only while no request
// is in progress, as the block itself does not enforce this.
module vertex_weld_by_distance_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [15:0]                         distance_threshold,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                first_of_set,
	input  wire logic signed [15:0]                  pos_x,
	input  wire logic signed [15:0]                  pos_y,
	input  wire logic signed [15:0]                  pos_z,
	input  wire logic [7:0]                          color_red,
	input  wire logic [7:0]                          color_green,
	input  wire logic [7:0]                          color_blue,
	output logic                                     done,
	output logic                                     is_unique,
	output logic                                     store_overflow,
	output logic [9:0]                               unique_index,
	output logic signed [15:0]                       out_x,
	output logic signed [15:0]                       out_y,
	output logic signed [15:0]                       out_z,
	output logic [7:0]                               out_red,
	output logic [7:0]                               out_green,
	output logic [7:0]                               out_blue
);

	vwbd_pkg::state_t                      state_q;
	vwbd_pkg::state_t                      state_d;
	logic [vwbd_pkg::SQ_W-1:0]             limit_q;
	logic [vwbd_pkg::CNT_W-1:0]            kept_count_q;
	logic [vwbd_pkg::CNT_W-1:0]            addr_q;
	logic                                  rd_valid_q;
	logic                                  hit_seen_q;
	logic [vwbd_pkg::COORD_W-1:0]          x_q;
	logic [vwbd_pkg::COORD_W-1:0]          y_q;
	logic [vwbd_pkg::COORD_W-1:0]          z_q;
	logic [vwbd_pkg::COLOR_W-1:0]          red_q;
	logic [vwbd_pkg::COLOR_W-1:0]          green_q;
	logic [vwbd_pkg::COLOR_W-1:0]          blue_q;
	logic                                  done_q;
	logic                                  unique_q;
	logic                                  overflow_q;
	logic [vwbd_pkg::IDX_W-1:0]            index_q;
	logic                                  accept;
	logic                                  issue;
	logic                                  flush;
	logic                                  full;
	logic                                  store_wr;
	logic [2*vwbd_pkg::COORD_W-1:0]        rd_data;
	vwbd_pkg::dist_status_t                dist_st;

	assign accept = start & ~busy;
	assign full   = (kept_count_q == vwbd_pkg::CNT_W'(vwbd_pkg::MAX_UNIQUE));

	// squared threshold, worked out once per register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= distance_threshold * distance_threshold;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vwbd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and scan control
	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		issue    = 1'b0;
		flush    = 1'b1;
		store_wr = 1'b0;
		unique case (state_q)
			vwbd_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = vwbd_pkg::ST_SCAN;
				end
			end
			vwbd_pkg::ST_SCAN: begin
				issue = (addr_q < kept_count_q) & ~dist_st.hit;
				flush = dist_st.hit;
				if (dist_st.hit) begin
					state_d = vwbd_pkg::ST_FINISH;
				end else if (!issue && !rd_valid_q && !dist_st.pending) begin
					state_d = vwbd_pkg::ST_FINISH;
				end
			end
			vwbd_pkg::ST_FINISH: begin
				store_wr = ~hit_seen_q & ~full;
				state_d  = vwbd_pkg::ST_IDLE;
			end
			default: begin
				state_d = vwbd_pkg::ST_IDLE;
			end
		endcase
	end

	// scan address, read valid, hit flag and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			rd_valid_q   <= 1'b0;
			hit_seen_q   <= 1'b0;
			kept_count_q <= '0;
		end else begin
			rd_valid_q <= issue;
			if (accept) begin
				addr_q     <= '0;
				hit_seen_q <= 1'b0;
				if (first_of_set) begin
					kept_count_q <= '0;
				end
			end else begin
				if (issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (dist_st.hit) begin
					hit_seen_q <= 1'b1;
				end
				if (store_wr) begin
					kept_count_q <= kept_count_q + 1'b1;
				end
			end
		end
	end

	// request fields held for the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= pos_x;
			y_q     <= pos_y;
			z_q     <= pos_z;
			red_q   <= color_red;
			green_q <= color_green;
			blue_q  <= color_blue;
		end
	end

	// position store
	vwbd_store u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (kept_count_q[vwbd_pkg::IDX_W-1:0]),
		.wr_data ({x_q, y_q}),
		.rd_addr (addr_q[vwbd_pkg::IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// shared distance unit
	vwbd_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid_q & (state_q == vwbd_pkg::ST_SCAN)),
		.flush    (flush),
		.ref_x    (x_q),
		.ref_y    (y_q),
		.kept_x   (rd_data[2*vwbd_pkg::COORD_W-1:vwbd_pkg::COORD_W]),
		.kept_y   (rd_data[vwbd_pkg::COORD_W-1:0]),
		.limit    (limit_q),
		.status   (dist_st)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == vwbd_pkg::ST_FINISH);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == vwbd_pkg::ST_FINISH) begin
			unique_q   <= ~hit_seen_q;
			overflow_q <= ~hit_seen_q & full;
			index_q    <= store_wr ? kept_count_q[vwbd_pkg::IDX_W-1:0] : '0;
		end
	end

	assign done           = done_q;
	assign is_unique      = unique_q;
	assign store_overflow = overflow_q;
	assign unique_index   = index_q;
	assign out_x          = x_q;
	assign out_y          = y_q;
	assign out_z          = z_q;
	assign out_red        = red_q;
	assign out_green      = green_q;
	assign out_blue       = blue_q;

	// overflow is only ever reported for a unique vertex
	a_overflow_unique: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!store_overflow || is_unique))
		else $error("overflow reported for a rejected vertex");

	// the kept count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q <= vwbd_pkg::CNT_W'(vwbd_pkg::MAX_UNIQUE))
		else $error("kept count beyond store depth");

	// a result follows the finishing cycle and the block is free then
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vwbd_pkg::ST_FINISH) |=> (done && !busy))
		else $error("result strobe missing after finish");

endmodule

`default_nettype wire
